/* rtl/keyed_record_table_defines.svh */
// ----------------------------------------------------------------------------
// keyed_record_table_defines.svh
// assertion macros shared by the keyed record table
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

// same-cycle implication, switched off while reset is high
`define KRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, switched off while reset is high
`define KRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg
// types, codes and sizes shared by the keyed record table
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

   localparam int KEY_W           = 16;
   localparam int COUNT_W         = 16;
   localparam int MAX_ENTRIES_DEF = 64;
   localparam int Q_DEPTH         = 2;

   // request codes as they arrive on the port
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_UPDATE = 2'd2;
   localparam logic [1:0] REQ_LOOKUP = 2'd3;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_UPDATE = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_PRESENT   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ENG_IDLE  = 2'd0,
      ENG_SCAN  = 2'd1,
      ENG_EXEC  = 2'd2,
      ENG_SHIFT = 2'd3
   } eng_state_type;

   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } rec_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] count;
   } eng_rsp_type;

endpackage

`default_nettype wire

/* rtl/krt_fifo.sv */
// ----------------------------------------------------------------------------
// krt_fifo
// small register queue that decouples two sides of the table
// ----------------------------------------------------------------------------
`default_nettype none

module krt_fifo #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic                   empty,
   output logic      [DATA_W-1:0] pop_data
);

   localparam int PW = (krt_pkg::Q_DEPTH > 1) ? $clog2(krt_pkg::Q_DEPTH) : 1;
   localparam int CW = $clog2(krt_pkg::Q_DEPTH + 1);

   logic [DATA_W-1:0] data_ff [krt_pkg::Q_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   // status and head of queue
   assign full     = (count_ff == CW'(krt_pkg::Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = data_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(krt_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(krt_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/krt_front.sv */
// ----------------------------------------------------------------------------
// krt_front
// request intake: decodes the request kind and queues the command
// ----------------------------------------------------------------------------
`default_nettype none

module krt_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [1:0]                    req_type,
   input  wire logic [krt_pkg::KEY_W-1:0]     req_key,
   input  wire logic [krt_pkg::COUNT_W-1:0]   req_count_value,
   output logic                               cmd_valid,
   output krt_pkg::cmd_type                   cmd,
   input  wire logic                          cmd_take
);

   localparam int CMD_W = $bits(krt_pkg::cmd_type);

   krt_pkg::cmd_type  cmd_dec;
   logic [CMD_W-1:0]  q_data;
   logic              q_empty;

   // classify the request kind
   always_comb begin
      cmd_dec.key   = req_key;
      cmd_dec.count = req_count_value;
      case (req_type)
         krt_pkg::REQ_INSERT: cmd_dec.op = krt_pkg::OP_INSERT;
         krt_pkg::REQ_REMOVE: cmd_dec.op = krt_pkg::OP_REMOVE;
         krt_pkg::REQ_UPDATE: cmd_dec.op = krt_pkg::OP_UPDATE;
         krt_pkg::REQ_LOOKUP: cmd_dec.op = krt_pkg::OP_LOOKUP;
         default:             cmd_dec.op = krt_pkg::OP_LOOKUP;
      endcase
   end

   // command queue towards the engine
   krt_fifo #(
      .DATA_W (CMD_W)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .push_data (CMD_W'(cmd_dec)),
      .pop       (cmd_take),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   assign cmd_valid = !q_empty;
   assign cmd       = krt_pkg::cmd_type'(q_data);

endmodule

`default_nettype wire

/* rtl/krt_engine.sv */
// ----------------------------------------------------------------------------
// krt_engine
// back end: record memory, key scan, insert, update, lookup and remove with shift
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_record_table_defines.svh"

module krt_engine #(
   parameter int MAX_ENTRIES = krt_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  cmd_valid,
   input  wire krt_pkg::cmd_type                      cmd,
   output logic                                       cmd_take,
   input  wire logic                                  rsp_full,
   output logic                                       rsp_push,
   output krt_pkg::eng_rsp_type                       rsp,
   output logic [$clog2(MAX_ENTRIES + 1)-1:0]         rsp_fill
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   krt_pkg::rec_type                 rec_mem_ff [MAX_ENTRIES];
   krt_pkg::rec_type                 rd_data_ff;
   krt_pkg::eng_state_type           state_ff, state_in;
   krt_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [CW-1:0]                    fill_ff, fill_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic                             pend_ff, pend_in;
   logic [AW-1:0]                    cmp_idx_ff, cmp_idx_in;
   logic                             hit_ff, hit_in;
   logic [AW-1:0]                    pos_ff, pos_in;
   logic [krt_pkg::COUNT_W-1:0]      hit_count_ff, hit_count_in;

   logic                             issue;
   logic                             hit_now;
   logic [AW-1:0]                    rd_addr;
   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   krt_pkg::rec_type                 wr_data;

   assign issue   = (idx_ff < fill_ff);
   assign hit_now = pend_ff && (rd_data_ff.key == cmd_ff.key);
   assign rd_addr = idx_ff[AW-1:0];

   // sequencer: scan one record a cycle, then act on the result
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      hit_count_in = hit_count_ff;
      cmd_take     = 1'b0;
      rsp_push     = 1'b0;
      rsp.status   = krt_pkg::ST_OK;
      rsp.count    = '0;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data.key  = cmd_ff.key;
      wr_data.count = cmd_ff.count;

      case (state_ff)
         krt_pkg::ENG_IDLE: begin
            // take a command only when its result has room
            if (cmd_valid && !rsp_full) begin
               cmd_take = 1'b1;
               cmd_in   = cmd;
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = krt_pkg::ENG_SCAN;
            end
         end

         krt_pkg::ENG_SCAN: begin
            if (hit_now) begin
               hit_in       = 1'b1;
               pos_in       = cmp_idx_ff;
               hit_count_in = rd_data_ff.count;
               state_in     = krt_pkg::ENG_EXEC;
            end else if (issue) begin
               idx_in     = idx_ff + CW'(1);
               pend_in    = 1'b1;
               cmp_idx_in = idx_ff[AW-1:0];
            end else begin
               hit_in   = 1'b0;
               state_in = krt_pkg::ENG_EXEC;
            end
         end

         krt_pkg::ENG_EXEC: begin
            rsp_push = 1'b1;
            state_in = krt_pkg::ENG_IDLE;
            if (cmd_ff.op == krt_pkg::OP_INSERT) begin
               if (hit_ff) begin
                  rsp.status = krt_pkg::ST_PRESENT;
                  rsp.count  = hit_count_ff;
               end else if (fill_ff == CW'(MAX_ENTRIES)) begin
                  rsp.status = krt_pkg::ST_FULL;
               end else begin
                  wr_en     = 1'b1;
                  wr_addr   = fill_ff[AW-1:0];
                  fill_in   = fill_ff + CW'(1);
                  rsp.count = cmd_ff.count;
               end
            end else if (!hit_ff) begin
               rsp.status = krt_pkg::ST_NOT_FOUND;
            end else if (cmd_ff.op == krt_pkg::OP_UPDATE) begin
               wr_en     = 1'b1;
               rsp.count = cmd_ff.count;
            end else if (cmd_ff.op == krt_pkg::OP_LOOKUP) begin
               rsp.count = hit_count_ff;
            end else begin
               // remove: close the gap before answering
               rsp_push = 1'b0;
               idx_in   = CW'(pos_ff) + CW'(1);
               pend_in  = 1'b0;
               state_in = krt_pkg::ENG_SHIFT;
            end
         end

         krt_pkg::ENG_SHIFT: begin
            // read one place ahead, write the record read last cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               pos_in  = pos_ff + AW'(1);
            end
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end else if (!pend_ff) begin
               fill_in  = fill_ff - CW'(1);
               rsp_push = 1'b1;
               state_in = krt_pkg::ENG_IDLE;
            end
         end

         default: begin
            state_in = krt_pkg::ENG_IDLE;
         end
      endcase
   end

   assign rsp_fill = fill_in;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= krt_pkg::ENG_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      pos_ff       <= pos_in;
      hit_count_ff <= hit_count_in;
   end

   // record memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= rec_mem_ff[rd_addr];
   end

   // checks
   `KRT_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(MAX_ENTRIES), "fill over capacity")
   `KRT_ASSERT_NOW(a_push_room, clock, reset, rsp_push, !rsp_full, "result pushed into full queue")
   `KRT_ASSERT_NEXT(a_take_scan, clock, reset, cmd_take, state_ff == krt_pkg::ENG_SCAN, "no scan after take")
   `KRT_ASSERT_NOW(a_full_status, clock, reset, rsp_push && (rsp.status == krt_pkg::ST_FULL), fill_ff == CW'(MAX_ENTRIES), "full status below capacity")

endmodule

`default_nettype wire

/* rtl/keyed_record_table.sv */
// ----------------------------------------------------------------------------
// keyed_record_table
// packed table of keyed records with insert, remove, update and lookup
// ----------------------------------------------------------------------------
//
//   channel    direction   handshake       payload
//   request    in          push / full     req_type, req_key, req_count_value
//   response   out         pop / empty     rsp_status, rsp_count_out,
//                                          rsp_entries_held
//
// one request is worked on at a time; the key scan reads the record memory, with its
// one read and one write port, one place a cycle up to and including a match (all held
// records on a miss); a successful remove adds a shift pass that moves each later record
// down one place, again one place a cycle through the memory ports
// reset clears the queues and the fill level; records need no clearing pass
// two-entry queues on both sides let requests and responses stall independently
//
`default_nettype none

module keyed_record_table #(
   parameter int MAX_ENTRIES = krt_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic [1:0]                            req_type,
   input  wire logic [krt_pkg::KEY_W-1:0]             req_key,
   input  wire logic [krt_pkg::COUNT_W-1:0]           req_count_value,
   output logic                                       empty,
   input  wire logic                                  pop,
   output logic [1:0]                                 rsp_status,
   output logic [krt_pkg::COUNT_W-1:0]                rsp_count_out,
   output logic [$clog2(MAX_ENTRIES + 1)-1:0]         rsp_entries_held
);

   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int RSP_W = $bits(krt_pkg::eng_rsp_type) + CW;

   logic                    cmd_valid;
   krt_pkg::cmd_type        cmd;
   logic                    cmd_take;
   logic                    rsp_full;
   logic                    rsp_push;
   krt_pkg::eng_rsp_type    eng_rsp;
   logic [CW-1:0]           eng_fill;
   logic [RSP_W-1:0]        rsp_data;
   krt_pkg::eng_rsp_type    head_rsp;

   // request intake
   krt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_count_value (req_count_value),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take)
   );

   // table engine
   krt_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (eng_rsp),
      .rsp_fill  (eng_fill)
   );

   // response queue
   krt_fifo #(
      .DATA_W (RSP_W)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .full      (rsp_full),
      .push_data ({eng_rsp, eng_fill}),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (rsp_data)
   );

   // unpack the head response
   assign head_rsp         = krt_pkg::eng_rsp_type'(rsp_data[RSP_W-1:CW]);
   assign rsp_status       = 2'(head_rsp.status);
   assign rsp_count_out    = head_rsp.count;
   assign rsp_entries_held = rsp_data[CW-1:0];

endmodule

`default_nettype wire
